[hw/rtl/sgfe_pkg.sv]
// Shared types and constants for the seven-bit group frame encoder.
package sgfe_pkg;

  localparam logic [7:0] StartMark = 8'h80;
  localparam logic [7:0] EndMark   = 8'h81;
  localparam logic [6:0] Low7Mask  = 7'h7F;
  localparam int unsigned GroupSize = 7;
  localparam logic [2:0] LastPos   = 3'(GroupSize - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TOP,
    ST_DATA,
    ST_END
  } sgfe_state_e;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_TOP,
    SEL_DATA,
    SEL_END
  } sgfe_sel_e;

  typedef struct packed {
    logic      load;
    logic      rd_step;
    sgfe_sel_e sel;
  } sgfe_cmd_t;

  typedef struct packed {
    logic need_start;
    logic flush;
    logic last;
    logic rd_at_end;
  } sgfe_status_t;

endpackage

[hw/rtl/sgfe_if.sv]
// Request channel interfaces for encoder input bytes and encoded output bytes.
interface sgfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface sgfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

[hw/rtl/seven_bit_group_frame_encoder.sv]
// Top level of the seven-bit group frame encoder.
// First result: offered in the cycle after the request is accepted when it opens a frame (start
// marker); otherwise, if it flushes a group, ST_START hands over to ST_TOP for the top-bit byte.
// Flow: one request at a time; the controller returns to idle after each request's results,
// and results are held while out_o.ready is low.
// Reset: asynchronous active-low rst_ni clears frame state, group count and top bits;
// stored group bytes are not reset.
module seven_bit_group_frame_encoder import sgfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgfe_in_if.sink    in_i,
  sgfe_out_if.source out_o
);

  sgfe_cmd_t    cmd;
  sgfe_status_t status;

  sgfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .run_last_o  (out_o.run_last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgfe_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (in_i.data_byte),
    .frame_last_i (in_i.frame_last),
    .status_o     (status),
    .out_byte_o   (out_o.out_byte)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input accepted while results pending");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && cmd.sel == SEL_END) |-> out_o.run_last)
    else $error("end marker not flagged last");

  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.run_last) |=> (in_i.ready && !out_o.valid))
    else $error("results continue after final one");

  a_top_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && cmd.sel == SEL_TOP) |-> !out_o.run_last)
    else $error("top-bit byte flagged last");

endmodule

[hw/rtl/sgfe_dpath.sv]
// Datapath: group byte store, top-bit gathering, frame state and output byte mux.
module sgfe_dpath import sgfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sgfe_cmd_t    cmd_i,
  input  logic [7:0]   data_byte_i,
  input  logic         frame_last_i,
  output sgfe_status_t status_o,
  output logic [7:0]   out_byte_o
);

  logic [6:0] held_q [GroupSize];
  logic [6:0] top_bits_q, top_bits_d;
  logic [2:0] group_count_q, group_count_d;
  logic       in_frame_q, in_frame_d;
  logic [6:0] out_top_q;
  logic [2:0] end_idx_q;
  logic [2:0] rd_idx_q, rd_idx_d;
  logic       need_start_q, flush_q, last_q;
  logic [2:0] pos;
  logic [6:0] top_new;
  logic       flush_now;

  assign pos       = (group_count_q > LastPos) ? 3'd0 : group_count_q;
  assign top_new   = top_bits_q | ({6'd0, data_byte_i[7]} << (LastPos - pos));
  assign flush_now = (pos == LastPos) || frame_last_i;

  always_comb begin
    top_bits_d    = top_bits_q;
    group_count_d = group_count_q;
    in_frame_d    = in_frame_q;
    rd_idx_d      = rd_idx_q;
    if (cmd_i.load) begin
      in_frame_d = !frame_last_i;
      rd_idx_d   = 3'd0;
      if (flush_now) begin
        top_bits_d    = 7'd0;
        group_count_d = 3'd0;
      end else begin
        top_bits_d    = top_new;
        group_count_d = pos + 3'd1;
      end
    end else if (cmd_i.rd_step) begin
      rd_idx_d = rd_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_bits_q    <= 7'd0;
      group_count_q <= 3'd0;
      in_frame_q    <= 1'b0;
      rd_idx_q      <= 3'd0;
      need_start_q  <= 1'b0;
      flush_q       <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      top_bits_q    <= top_bits_d;
      group_count_q <= group_count_d;
      in_frame_q    <= in_frame_d;
      rd_idx_q      <= rd_idx_d;
      if (cmd_i.load) begin
        need_start_q <= !in_frame_q;
        flush_q      <= flush_now;
        last_q       <= frame_last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q[pos] <= data_byte_i[6:0] & Low7Mask;
      out_top_q   <= top_new;
      end_idx_q   <= pos;
    end
  end

  assign status_o = '{
    need_start: need_start_q,
    flush:      flush_q,
    last:       last_q,
    rd_at_end:  (rd_idx_q == end_idx_q)
  };

  always_comb begin
    unique case (cmd_i.sel)
      SEL_START: out_byte_o = StartMark;
      SEL_TOP:   out_byte_o = {1'b0, out_top_q};
      SEL_DATA:  out_byte_o = {1'b0, held_q[rd_idx_q]};
      SEL_END:   out_byte_o = EndMark;
      default:   out_byte_o = EndMark;
    endcase
  end

endmodule

[hw/rtl/sgfe_ctrl.sv]
// Controller: sequences start marker, top-bit byte, group bytes and end marker.
module sgfe_ctrl import sgfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         run_last_o,
  input  sgfe_status_t status_i,
  output sgfe_cmd_t    cmd_o
);

  sgfe_state_e state_q, state_d;
  logic        out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        if (!status_i.need_start) begin
          state_d = status_i.flush ? ST_TOP : ST_IDLE;
        end else if (out_fire) begin
          state_d = status_i.flush ? ST_TOP : ST_IDLE;
        end
      end
      ST_TOP: begin
        if (out_fire) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (out_fire && status_i.rd_at_end) begin
          state_d = status_i.last ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (out_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    run_last_o  = 1'b0;
    cmd_o       = '{load: 1'b0, rd_step: 1'b0, sel: SEL_START};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: begin
        out_valid_o = status_i.need_start;
        run_last_o  = !status_i.flush;
      end
      ST_TOP: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_TOP;
      end
      ST_DATA: begin
        out_valid_o   = 1'b1;
        run_last_o    = status_i.rd_at_end && !status_i.last;
        cmd_o.sel     = SEL_DATA;
        cmd_o.rd_step = out_ready_i && !status_i.rd_at_end;
      end
      ST_END: begin
        out_valid_o = 1'b1;
        run_last_o  = 1'b1;
        cmd_o.sel   = SEL_END;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
